>>> hdl/stbc_pkg.sv
// stbc_pkg: types, character codes and byte classes for the shell word bounds block.
// No dependencies; every other file imports it.

package stbc_pkg;

    localparam int unsigned POS_W = 13;
    localparam int unsigned BYTE_W = 8;

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [BYTE_W-1:0] byte_t;

    // Longest line taken; later bytes are dropped and flagged.
    localparam pos_t MAX_LINE = pos_t'(4096);

    localparam byte_t CH_TAB = 8'h09;
    localparam byte_t CH_LF = 8'h0A;
    localparam byte_t CH_VT = 8'h0B;
    localparam byte_t CH_FF = 8'h0C;
    localparam byte_t CH_CR = 8'h0D;
    localparam byte_t CH_SPACE = 8'h20;
    localparam byte_t CH_DQUOTE = 8'h22;
    localparam byte_t CH_DOLLAR = 8'h24;
    localparam byte_t CH_AMP = 8'h26;
    localparam byte_t CH_SQUOTE = 8'h27;
    localparam byte_t CH_LPAREN = 8'h28;
    localparam byte_t CH_SEMI = 8'h3B;
    localparam byte_t CH_BSLASH = 8'h5C;
    localparam byte_t CH_BAR = 8'h7C;

    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_ESCAPE  = 3'd1,
        MODE_SQUOTE  = 3'd2,
        MODE_DSQUOTE = 3'd3,
        MODE_DQUOTE  = 3'd4,
        MODE_WAIT    = 3'd5,
        MODE_DONE    = 3'd6
    } scan_mode_t;

    // Quote/escape state of one scanner.
    typedef struct packed {
        scan_mode_t mode;
        logic       esc;
    } scan_state_t;

    // One scanner step: next state and whether the byte ended a word.
    typedef struct packed {
        scan_state_t state;
        logic        hit;
    } scan_step_t;

    localparam scan_state_t SCAN_IDLE = '{mode: MODE_NORMAL, esc: 1'b0};
    localparam scan_state_t SCAN_WAIT = '{mode: MODE_WAIT, esc: 1'b0};

    function automatic logic is_boundary(input byte_t b);
        return b inside {CH_SPACE, CH_TAB, CH_CR, CH_VT, CH_FF, CH_LF,
                         CH_SEMI, CH_BAR, CH_AMP, CH_LPAREN};
    endfunction

endpackage

>>> hdl/stbc_if.sv
// stbc_line_if / stbc_bounds_if: valid/ready channels for line bytes and word bounds.
// Depends on stbc_pkg.

interface stbc_line_if;
    import stbc_pkg::*;

    logic  valid;
    logic  ready;
    byte_t line_byte;
    logic  is_last_byte;

    modport source (output valid, output line_byte, output is_last_byte, input ready);
    modport sink (input valid, input line_byte, input is_last_byte, output ready);
endinterface

interface stbc_bounds_if;
    import stbc_pkg::*;

    logic valid;
    logic ready;
    pos_t token_start;
    pos_t word_end;
    logic line_too_long;

    modport source (output valid, output token_start, output word_end,
                    output line_too_long, input ready);
    modport sink (input valid, input token_start, input word_end,
                  input line_too_long, output ready);
endinterface

>>> hdl/stbc_scan_step.sv
// stbc_scan_step: one byte of quote/escape tracking for a word scanner.
// Depends on stbc_pkg.

module stbc_scan_step (
    input  stbc_pkg::scan_state_t cur,
    input  stbc_pkg::byte_t       b,
    input  logic                  active,
    input  logic                  dollar_quote,
    output stbc_pkg::scan_step_t  step
);
    import stbc_pkg::*;

    always_comb
    begin
        step.state = cur;
        step.hit = 1'b0;
        case (cur.mode)
            MODE_ESCAPE:
            begin
                step.state.mode = MODE_NORMAL;
            end
            MODE_SQUOTE:
            begin
                if (b == CH_SQUOTE)
                    step.state.mode = MODE_NORMAL;
            end
            MODE_DSQUOTE, MODE_DQUOTE:
            begin
                // bodies of these quotes honor backslash escapes
                if (cur.esc)
                    step.state.esc = 1'b0;
                else if (b == CH_BSLASH)
                    step.state.esc = 1'b1;
                else if (b == ((cur.mode == MODE_DQUOTE) ? CH_DQUOTE : CH_SQUOTE))
                    step.state.mode = MODE_NORMAL;
            end
            default:
            begin
                step.state.esc = 1'b0;
                if (b == CH_BSLASH)
                    step.state.mode = MODE_ESCAPE;
                else if (b == CH_SQUOTE)
                    step.state.mode = dollar_quote ? MODE_DSQUOTE : MODE_SQUOTE;
                else if (b == CH_DQUOTE)
                    step.state.mode = MODE_DQUOTE;
                else
                begin
                    step.state.mode = MODE_NORMAL;
                    step.hit = active;
                end
            end
        endcase
    end

endmodule

>>> hdl/shell_token_bounds_at_cursor_top.sv
// shell_token_bounds_at_cursor_top: word bounds around a cursor in a shell command line.
// Depends on stbc_pkg, stbc_line_if/stbc_bounds_if and stbc_scan_step.
//
// Usage:
//   line_chan carries the command line one byte per request, the final byte
//   flagged by is_last_byte. Lines are at least one byte long. bounds_chan
//   returns one request per line, after its final byte: token_start, word_end
//   and line_too_long (set when the line ran past MAX_LINE bytes; the extra
//   bytes are dropped).
//   cursor is written through cfg_wen/cfg_wdata between lines.
// Timing:
//   A byte is captured in an input register, then the two scanners (start
//   and end) advance on it in one combinational step. The result lands in
//   an output register when the final byte is processed. One byte per cycle
//   sustained: line_chan stays ready while a result waits, and stalls only
//   when a final byte would need the output register while the previous
//   result is still unread.
// Reset:
//   rst_n clears the cursor to 0, both scanners and all per-line state.
//   The per-line state also returns to its start values after each final byte.

module shell_token_bounds_at_cursor_top (
    input  logic                 clk,
    input  logic                 rst_n,
    stbc_line_if.sink            line_chan,
    stbc_bounds_if.source        bounds_chan,
    input  logic                 cfg_wen,
    input  stbc_pkg::pos_t       cfg_wdata
);
    import stbc_pkg::*;

    // configuration
    pos_t cursor_reg;

    // input register
    logic  in_valid_reg;
    byte_t in_byte_reg;
    logic  in_last_reg;

    // per-line state
    pos_t        pos_reg, pos_next;
    byte_t       prev_reg, prev_next;
    logic        bs_odd_reg, bs_odd_next;
    logic        dollar_reg, dollar_next;
    scan_state_t start_st_reg, start_st_next;
    pos_t        start_off_reg, start_off_next;
    scan_state_t end_st_reg, end_st_next;
    pos_t        end_off_reg, end_off_next;
    logic        ovf_reg, ovf_next;

    // result register
    logic out_valid_reg, out_valid_next;
    pos_t res_start_reg, res_start_next;
    pos_t res_end_reg, res_end_next;
    logic res_ovf_reg, res_ovf_next;

    logic        proc;
    logic        active;
    logic        dollar_quote;
    scan_state_t end_in;
    scan_step_t  start_step;
    scan_step_t  end_step;

    // A final byte may only move on when the result slot is free this cycle.
    assign proc = in_valid_reg && (!in_last_reg || !out_valid_reg || bounds_chan.ready);
    assign line_chan.ready = !in_valid_reg || proc;

    // '(' glued to a preceding word byte is not a boundary
    assign active = is_boundary(in_byte_reg)
                    && !(in_byte_reg == CH_LPAREN && pos_reg != '0 && !is_boundary(prev_reg));
    assign dollar_quote = (in_byte_reg == CH_SQUOTE) && dollar_reg;

    // end scanner starts fresh at the cursor
    assign end_in = (end_st_reg.mode == MODE_WAIT && pos_reg == cursor_reg) ? SCAN_IDLE
                                                                           : end_st_reg;

    stbc_scan_step u_start_scan (
        .cur          (start_st_reg),
        .b            (in_byte_reg),
        .active       (active),
        .dollar_quote (dollar_quote),
        .step         (start_step)
    );

    stbc_scan_step u_end_scan (
        .cur          (end_in),
        .b            (in_byte_reg),
        .active       (active),
        .dollar_quote (dollar_quote),
        .step         (end_step)
    );

    always_comb
    begin
        pos_t        upd_pos;
        pos_t        upd_start_off;
        pos_t        upd_end_off;
        scan_state_t upd_start_st;
        scan_state_t upd_end_st;
        logic        upd_ovf;

        upd_pos = pos_reg;
        upd_start_off = start_off_reg;
        upd_end_off = end_off_reg;
        upd_start_st = start_st_reg;
        upd_end_st = end_st_reg;
        upd_ovf = ovf_reg;

        pos_next = pos_reg;
        prev_next = prev_reg;
        bs_odd_next = bs_odd_reg;
        dollar_next = dollar_reg;
        start_st_next = start_st_reg;
        start_off_next = start_off_reg;
        end_st_next = end_st_reg;
        end_off_next = end_off_reg;
        ovf_next = ovf_reg;

        res_start_next = res_start_reg;
        res_end_next = res_end_reg;
        res_ovf_next = res_ovf_reg;
        out_valid_next = out_valid_reg && !bounds_chan.ready;

        if (proc)
        begin
            if (pos_reg >= MAX_LINE)
            begin
                upd_ovf = 1'b1;
            end
            else
            begin
                if (pos_reg < cursor_reg)
                begin
                    upd_start_st = start_step.state;
                    if (start_step.hit)
                        upd_start_off = pos_reg + pos_t'(1);
                end

                upd_end_st = end_in;
                if (end_in.mode != MODE_WAIT && end_in.mode != MODE_DONE)
                begin
                    upd_end_st = end_step.state;
                    if (end_step.hit)
                    begin
                        upd_end_off = pos_reg;
                        upd_end_st.mode = MODE_DONE;
                    end
                end

                dollar_next = (in_byte_reg == CH_DOLLAR) && !bs_odd_reg;
                bs_odd_next = (in_byte_reg == CH_BSLASH) ? !bs_odd_reg : 1'b0;
                prev_next = in_byte_reg;
                upd_pos = pos_reg + pos_t'(1);
            end

            pos_next = upd_pos;
            start_st_next = upd_start_st;
            start_off_next = upd_start_off;
            end_st_next = upd_end_st;
            end_off_next = upd_end_off;
            ovf_next = upd_ovf;

            if (in_last_reg)
            begin
                out_valid_next = 1'b1;
                res_start_next = upd_start_off;
                res_ovf_next = upd_ovf;
                if (upd_end_st.mode == MODE_DONE)
                    res_end_next = upd_end_off;
                else if (cursor_reg >= upd_pos)
                    res_end_next = (cursor_reg > MAX_LINE) ? MAX_LINE : cursor_reg;
                else
                    res_end_next = upd_pos;

                // fresh line
                pos_next = '0;
                prev_next = '0;
                bs_odd_next = 1'b0;
                dollar_next = 1'b0;
                start_st_next = SCAN_IDLE;
                start_off_next = '0;
                end_st_next = SCAN_WAIT;
                end_off_next = '0;
                ovf_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg <= '0;
            prev_reg <= '0;
            bs_odd_reg <= 1'b0;
            dollar_reg <= 1'b0;
            start_st_reg <= SCAN_IDLE;
            start_off_reg <= '0;
            end_st_reg <= SCAN_WAIT;
            end_off_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
                cursor_reg <= cfg_wdata;
            if (line_chan.ready)
                in_valid_reg <= line_chan.valid;
            out_valid_reg <= out_valid_next;
            pos_reg <= pos_next;
            prev_reg <= prev_next;
            bs_odd_reg <= bs_odd_next;
            dollar_reg <= dollar_next;
            start_st_reg <= start_st_next;
            start_off_reg <= start_off_next;
            end_st_reg <= end_st_next;
            end_off_reg <= end_off_next;
            ovf_reg <= ovf_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (line_chan.ready && line_chan.valid)
        begin
            in_byte_reg <= line_chan.line_byte;
            in_last_reg <= line_chan.is_last_byte;
        end
        res_start_reg <= res_start_next;
        res_end_reg <= res_end_next;
        res_ovf_reg <= res_ovf_next;
    end

    assign bounds_chan.valid = out_valid_reg;
    assign bounds_chan.token_start = res_start_reg;
    assign bounds_chan.word_end = res_end_reg;
    assign bounds_chan.line_too_long = res_ovf_reg;

endmodule
